FILE: rtl/sh9_radiance_irradiance_eval_defines.svh
// Assertion macros shared by the SH9 evaluator top level.
// No dependencies.
`ifndef SH9_RADIANCE_IRRADIANCE_EVAL_DEFINES_SVH
`define SH9_RADIANCE_IRRADIANCE_EVAL_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SH9_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SH9_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/sh9_pkg.sv
// Package for the SH9 evaluator: basis constants, item kinds and shared types.
// No dependencies.
package sh9_pkg;
    localparam int NUM_SLOTS  = 9;
    localparam int BASIS_W    = 28;
    localparam int NUM_STAGES = 9;

    typedef enum logic { KIND_LOAD = 1'b0, KIND_EVAL = 1'b1 } kind_t;

    // Basis constants in Q.24: index 0 radiance, 1 irradiance.
    localparam logic signed [27:0] K0 [2] = '{28'sd4732769, 28'sd14868432};
    localparam logic signed [27:0] K1 [2] = '{28'sd8197398, 28'sd17168590};
    localparam logic signed [27:0] K2 [2] = '{28'sd18329914, 28'sd14396281};
    localparam logic signed [27:0] K3 [2] = '{28'sd5291400, 28'sd4155856};
    localparam logic signed [27:0] K4 [2] = '{28'sd9164957, 28'sd7198141};

    // Per-channel accumulator word handed from cell to cell.
    typedef struct packed {
        logic signed [63:0] red;
        logic signed [63:0] green;
        logic signed [63:0] blue;
    } acc_t;
endpackage

FILE: rtl/sh9_basis.sv
// Pipelined SH basis generator: two registered stages, direction products then band-constant scaling.
// Depends on sh9_pkg.
module sh9_basis #(
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic                aclk,
    input  logic                lobe,
    input  logic signed [15:0]  dir_x,
    input  logic signed [15:0]  dir_y,
    input  logic signed [15:0]  dir_z,
    output logic signed [sh9_pkg::BASIS_W-1:0] basis [sh9_pkg::NUM_SLOTS]
);
    import sh9_pkg::*;
    localparam int D = DIR_FRAC_BITS;

    logic signed [31:0] xy_reg, yz_reg, xz_reg, zz_reg, dd_reg;
    logic signed [15:0] x_reg, y_reg, z_reg;
    logic               lobe_reg;
    logic signed [63:0] p_next [NUM_SLOTS];
    logic signed [63:0] p_reg  [NUM_SLOTS];
    logic signed [63:0] k3_reg;

    // Stage one: direction products.
    always_ff @(posedge aclk) begin
        xy_reg   <= 32'(dir_x * dir_y);
        yz_reg   <= 32'(dir_y * dir_z);
        xz_reg   <= 32'(dir_x * dir_z);
        zz_reg   <= 32'(dir_z * dir_z);
        dd_reg   <= 32'(32'(dir_x * dir_x) - 32'(dir_y * dir_y));
        x_reg    <= dir_x;
        y_reg    <= dir_y;
        z_reg    <= dir_z;
        lobe_reg <= lobe;
    end

    // Stage two: scale by the band constants and add the rounding bias.
    always_comb begin
        p_next[0] = 64'(K0[lobe_reg]);
        p_next[1] = 64'(K1[lobe_reg]) * 64'(y_reg) + (64'sd1 <<< (D - 1));
        p_next[2] = 64'(K1[lobe_reg]) * 64'(z_reg) + (64'sd1 <<< (D - 1));
        p_next[3] = 64'(K1[lobe_reg]) * 64'(x_reg) + (64'sd1 <<< (D - 1));
        p_next[4] = 64'(K2[lobe_reg]) * 64'(xy_reg) + (64'sd1 <<< (2 * D - 1));
        p_next[5] = 64'(K2[lobe_reg]) * 64'(yz_reg) + (64'sd1 <<< (2 * D - 1));
        p_next[6] = 64'(K3[lobe_reg]) * 64'sd3 * 64'(zz_reg) + (64'sd1 <<< (2 * D - 1));
        p_next[7] = 64'(K2[lobe_reg]) * 64'(xz_reg) + (64'sd1 <<< (2 * D - 1));
        p_next[8] = 64'(K4[lobe_reg]) * 64'(dd_reg) + (64'sd1 <<< (2 * D - 1));
    end

    always_ff @(posedge aclk) begin
        p_reg  <= p_next;
        k3_reg <= 64'(K3[lobe_reg]);
    end

    // Shift, offset and saturate each term to Q3.24.
    always_comb begin
        logic signed [63:0] v;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i == 0) v = p_reg[i];
            else if (i < 4) v = p_reg[i] >>> D;
            else v = p_reg[i] >>> (2 * D);
            if (i == 6) v = v - k3_reg;
            if (v > 64'sd134217727) basis[i] = 28'sh7ffffff;
            else if (v < -64'sd134217728) basis[i] = 28'sh8000000;
            else basis[i] = v[27:0];
        end
    end
endmodule

FILE: rtl/sh9_mac_cell.sv
// One cell of the dot-product chain: holds one slot's RGB coefficients and
// adds its products to the passing accumulator word. Depends on sh9_pkg.
module sh9_mac_cell #(
    parameter int COEF_WIDTH = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load_en,
    input  logic signed [COEF_WIDTH-1:0]  load_red,
    input  logic signed [COEF_WIDTH-1:0]  load_green,
    input  logic signed [COEF_WIDTH-1:0]  load_blue,
    input  logic signed [sh9_pkg::BASIS_W-1:0] basis_in,
    input  sh9_pkg::acc_t                 acc_in,
    output sh9_pkg::acc_t                 acc_out
);
    import sh9_pkg::*;

    logic signed [COEF_WIDTH-1:0] red_reg, green_reg, blue_reg;
    acc_t acc_reg;

    // Coefficient slot, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end else if (load_en) begin
            red_reg   <= load_red;
            green_reg <= load_green;
            blue_reg  <= load_blue;
        end
    end

    // Multiply-accumulate into the word handed to the next cell.
    always_ff @(posedge aclk) begin
        acc_reg.red   <= acc_in.red + 64'(red_reg * basis_in);
        acc_reg.green <= acc_in.green + 64'(green_reg * basis_in);
        acc_reg.blue  <= acc_in.blue + 64'(blue_reg * basis_in);
    end

    assign acc_out = acc_reg;
endmodule

FILE: rtl/sh9_radiance_irradiance_eval.sv
// SH9 radiance/irradiance evaluator, top level.
// An accepted evaluate word passes the two basis stages, then one stage per cell
// of the nine-cell row, before its result enters the result queue.
// Throughput: one word per cycle; input stalls only when queued plus in-flight
// results fill the 16-entry result queue. Loads travel down the row in order.
// Reset (aresetn low, synchronous) clears all coefficients, lobe_reg and
// the valid pipeline.
module sh9_radiance_irradiance_eval #(
    parameter int COEF_WIDTH    = 24,
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // kind
    // coef_slot[3:0], coef_red, coef_green, coef_blue, dir_x, dir_y, dir_z, zero pad
    input  logic [4+3*COEF_WIDTH+48+((8-((4+3*COEF_WIDTH+48)%8))%8)-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // clipped
    // out_red, out_green, out_blue, zero pad
    output logic [3*COEF_WIDTH+((8-((3*COEF_WIDTH)%8))%8)-1:0] m_tdata
);
    import sh9_pkg::*;
    `include "sh9_radiance_irradiance_eval_defines.svh"

    localparam int CW  = COEF_WIDTH;
    localparam int MW  = 3*CW + ((8-((3*CW)%8))%8);
    localparam int LAT = NUM_STAGES + 2;
    localparam int SKW = 16;

    logic                 lobe_reg;
    logic [3:0]           slot;
    logic signed [CW-1:0] cr, cg, cb;
    logic signed [15:0]   dx, dy, dz;
    logic                 accept;
    logic signed [BASIS_W-1:0] basis [NUM_SLOTS];
    acc_t                 chain [NUM_SLOTS+1];
    logic                 vld_reg [LAT];
    logic                 ld_vld_reg [NUM_SLOTS];
    logic [3:0]           ld_slot_reg [NUM_SLOTS];
    logic signed [CW-1:0] ld_red_reg [NUM_SLOTS];
    logic signed [CW-1:0] ld_green_reg [NUM_SLOTS];
    logic signed [CW-1:0] ld_blue_reg [NUM_SLOTS];
    logic [SKW-1:0][CW-1:0] fifo_red_reg, fifo_green_reg, fifo_blue_reg;
    logic [SKW-1:0]       fifo_clip_reg;
    logic [3:0]           wp_reg, rp_reg;
    logic [4:0]           cnt_reg, cnt_next;
    logic [3:0]           inflight;
    logic signed [BASIS_W-1:0] bdel [NUM_SLOTS][NUM_SLOTS];
    logic signed [CW-1:0] res_r, res_g, res_b;
    logic                 res_clip;

    assign slot = s_tdata[3:0];
    assign cr   = s_tdata[4 +: CW];
    assign cg   = s_tdata[4+CW +: CW];
    assign cb   = s_tdata[4+2*CW +: CW];
    assign dx   = s_tdata[4+3*CW +: 16];
    assign dy   = s_tdata[4+3*CW+16 +: 16];
    assign dz   = s_tdata[4+3*CW+32 +: 16];

    // Configuration register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) lobe_reg <= 1'b0;
        else if (cfg_valid) lobe_reg <= cfg_data;
    end

    // Credit-based flow control: count evaluate words in flight plus queued results.
    always_comb begin
        inflight = '0;
        for (int i = 0; i < LAT; i++) inflight = inflight + 4'(vld_reg[i]);
    end
    assign s_tready = (32'(cnt_reg) + 32'(inflight)) < SKW;
    assign accept   = s_tvalid && s_tready;

    sh9_basis #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_basis (
        .aclk(aclk), .lobe(lobe_reg), .dir_x(dx), .dir_y(dy), .dir_z(dz),
        .basis(basis)
    );

    // Skew each basis term so cell i sees it when the word reaches it.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            bdel[i][0] <= basis[i];
            for (int j = 1; j < NUM_SLOTS; j++) bdel[i][j] <= bdel[i][j-1];
        end
    end

    // A load word walks down the row one cell per cycle, so it writes its slot
    // between the evaluate words that came before and after it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) ld_vld_reg[i] <= 1'b0;
        end else begin
            ld_vld_reg[0] <= accept && s_tuser == KIND_LOAD;
            for (int i = 1; i < NUM_SLOTS; i++) ld_vld_reg[i] <= ld_vld_reg[i-1];
        end
    end
    always_ff @(posedge aclk) begin
        ld_slot_reg[0]  <= slot;
        ld_red_reg[0]   <= cr;
        ld_green_reg[0] <= cg;
        ld_blue_reg[0]  <= cb;
        for (int i = 1; i < NUM_SLOTS; i++) begin
            ld_slot_reg[i]  <= ld_slot_reg[i-1];
            ld_red_reg[i]   <= ld_red_reg[i-1];
            ld_green_reg[i] <= ld_green_reg[i-1];
            ld_blue_reg[i]  <= ld_blue_reg[i-1];
        end
    end

    assign chain[0] = '0;
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        logic signed [BASIS_W-1:0] b_in;
        if (g == 0) begin : g_first
            assign b_in = basis[0];
        end else begin : g_rest
            assign b_in = bdel[g][g-1];
        end
        sh9_mac_cell #(.COEF_WIDTH(CW)) u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .load_en(ld_vld_reg[g] && ld_slot_reg[g] == 4'(g)),
            .load_red(ld_red_reg[g]), .load_green(ld_green_reg[g]),
            .load_blue(ld_blue_reg[g]),
            .basis_in(b_in), .acc_in(chain[g]), .acc_out(chain[g+1])
        );
    end

    // Valid shift line, matching the basis and cell pipeline depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) vld_reg[i] <= 1'b0;
        end else begin
            vld_reg[0] <= accept && s_tuser == KIND_EVAL;
            for (int i = 1; i < LAT; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Round and saturate each channel.
    function automatic logic signed [CW:0] sat(input logic signed [63:0] a);
        logic signed [63:0] r;
        r = (a + 64'sd8388608) >>> 24;
        if (r > 64'((64'sd1 <<< (CW - 1)) - 1)) sat = {1'b1, 1'b0, {(CW-1){1'b1}}};
        else if (r < -(64'sd1 <<< (CW - 1))) sat = {1'b1, 1'b1, {(CW-1){1'b0}}};
        else sat = {1'b0, r[CW-1:0]};
    endfunction

    always_comb begin
        logic signed [CW:0] a, b, c;
        a = sat(chain[NUM_SLOTS].red);
        b = sat(chain[NUM_SLOTS].green);
        c = sat(chain[NUM_SLOTS].blue);
        res_r = a[CW-1:0];
        res_g = b[CW-1:0];
        res_b = c[CW-1:0];
        res_clip = a[CW] | b[CW] | c[CW];
    end

    // Output queue.
    always_comb begin
        cnt_next = cnt_reg + 5'(vld_reg[LAT-1]) - 5'(m_tvalid && m_tready);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (vld_reg[LAT-1]) wp_reg <= wp_reg + 4'd1;
            if (m_tvalid && m_tready) rp_reg <= rp_reg + 4'd1;
            cnt_reg <= cnt_next;
        end
    end
    always_ff @(posedge aclk) begin
        if (vld_reg[LAT-1]) begin
            fifo_red_reg[wp_reg]   <= res_r;
            fifo_green_reg[wp_reg] <= res_g;
            fifo_blue_reg[wp_reg]  <= res_b;
            fifo_clip_reg[wp_reg]  <= res_clip;
        end
    end

    assign m_tvalid = cnt_reg != 5'd0;
    assign m_tuser  = fifo_clip_reg[rp_reg];
    assign m_tdata  = MW'({fifo_blue_reg[rp_reg], fifo_green_reg[rp_reg],
                          fifo_red_reg[rp_reg]});

    `SH9_ASSERT_IMP(a_no_overflow, aclk, aresetn, 1'b1, (32'(cnt_reg) + 32'(inflight)) <= SKW, "queue credit overrun")
    `SH9_ASSERT_IMP(a_valid_cnt, aclk, aresetn, m_tvalid, cnt_reg != 5'd0, "valid without data")
    `SH9_ASSERT_NXT(a_cnt_step, aclk, aresetn, vld_reg[LAT-1] && !(m_tvalid && m_tready), cnt_reg == $past(cnt_reg) + 5'd1, "queue count did not grow")
endmodule
